@@ src/skfl_pkg.sv @@
// Package for the steering kickout fault latch: payload structs, register
// indexes, reason and command codes, and reset values of the window and limit registers.
// No dependencies.
package skfl_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned ADC_W       = 12;
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned COUNT_W     = 32;
   localparam int unsigned REASON_W    = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ENCODER_ENABLE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESSURE_ENABLE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_ENABLE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_MAX       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_MS       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESSURE_LIMIT  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_LIMIT   = 3'd6;

   // reset values
   localparam logic [15:0]      WINDOW_MS_RST      = 16'd100;
   localparam logic [ADC_W-1:0] PRESSURE_LIMIT_RST = 12'd800;
   localparam logic [ADC_W-1:0] CURRENT_LIMIT_RST  = 12'd900;

   // command codes
   localparam logic CMD_POLL  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // kickout reasons
   localparam logic [REASON_W-1:0] REASON_NONE      = 2'd0;
   localparam logic [REASON_W-1:0] REASON_OVERSPEED = 2'd1;
   localparam logic [REASON_W-1:0] REASON_PRESSURE  = 2'd2;
   localparam logic [REASON_W-1:0] REASON_CURRENT   = 2'd3;

   typedef struct packed {
      logic              cmd;
      logic              encoder_level;
      logic [ADC_W-1:0]  pressure_sample;
      logic [ADC_W-1:0]  current_sample;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic                kickout_active;
      logic [REASON_W-1:0] kickout_reason;
      logic [TIME_W-1:0]   kickout_time_ms;
      logic [COUNT_W-1:0]  pulse_total;
   } rsp_type;

endpackage

@@ src/steering_kickout_fault_latch_top.sv @@
// Steering kickout fault latch: encoder edge counting, window overspeed check,
// pressure and current threshold checks, latched fault with reason and time.
// Depends on skfl_pkg.
//
// Usage:
//   req_*  : poll or clear words (req_valid / req_stall). A word is taken at a
//            rising edge with req_valid high and req_stall low.
//   rsp_*  : one result word per request: latch state and pulse total after
//            that request (rsp_valid / rsp_stall).
//   csr_*  : register writes (csr_valid / csr_ready, always ready); indexes
//            beyond the register list are dropped. Write only while idle.
// The result is registered: into the output word, or the skid word while that is held.
// Throughput: one request per cycle while req_stall is low. All checks are a
// single pass of logic from the request word to the result register; the 32-bit
// pulse count increment, window subtract and compare set the path length.
// The result register is backed by a one-word skid buffer, so a request is
// still taken while one result waits; req_stall rises only when both hold
// results, and falls once the receiver takes one.
// Reset (synchronous): latch, counts, window and prev level clear; config
// returns to its reset values; both output words empty.
module steering_kickout_fault_latch_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  skfl_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output skfl_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [skfl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [skfl_pkg::CSR_DATA_W-1:0]    csr_data
);

   // config registers
   logic                           encoder_enable_ff;
   logic                           pressure_enable_ff;
   logic                           current_enable_ff;
   logic [15:0]                    pulse_max_ff;
   logic [15:0]                    window_ms_ff;
   logic [skfl_pkg::ADC_W-1:0]     pressure_limit_ff;
   logic [skfl_pkg::ADC_W-1:0]     current_limit_ff;

   // block state
   logic                           prev_level_ff, prev_level_in;
   logic [skfl_pkg::COUNT_W-1:0]   pulse_count_ff, pulse_count_in;
   logic [skfl_pkg::COUNT_W-1:0]   window_base_ff, window_base_in;
   logic [skfl_pkg::TIME_W-1:0]    window_start_ff, window_start_in;
   logic                           latched_ff, latched_in;
   logic [skfl_pkg::REASON_W-1:0]  reason_ff, reason_in;
   logic [skfl_pkg::TIME_W-1:0]    latched_time_ff, latched_time_in;

   // output and skid words
   skfl_pkg::rsp_type              out_ff, out_in, skid_ff, skid_in;
   logic                           out_valid_ff, out_valid_in;
   logic                           skid_valid_ff, skid_valid_in;

   logic                           req_take;
   logic                           rsp_take;
   logic [skfl_pkg::COUNT_W-1:0]   count_step;
   logic [skfl_pkg::TIME_W-1:0]    elapsed;
   logic [skfl_pkg::COUNT_W-1:0]   window_pulses;
   logic                           window_done;
   logic                           over_trip;
   logic                           press_trip;
   logic                           curr_trip;
   skfl_pkg::rsp_type              result;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         encoder_enable_ff  <= 1'b0;
         pressure_enable_ff <= 1'b0;
         current_enable_ff  <= 1'b0;
         pulse_max_ff       <= '0;
         window_ms_ff       <= skfl_pkg::WINDOW_MS_RST;
         pressure_limit_ff  <= skfl_pkg::PRESSURE_LIMIT_RST;
         current_limit_ff   <= skfl_pkg::CURRENT_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            skfl_pkg::CSR_ENCODER_ENABLE:  encoder_enable_ff  <= csr_data[0];
            skfl_pkg::CSR_PRESSURE_ENABLE: pressure_enable_ff <= csr_data[0];
            skfl_pkg::CSR_CURRENT_ENABLE:  current_enable_ff  <= csr_data[0];
            skfl_pkg::CSR_PULSE_MAX:       pulse_max_ff       <= csr_data;
            skfl_pkg::CSR_WINDOW_MS:       window_ms_ff       <= csr_data;
            skfl_pkg::CSR_PRESSURE_LIMIT:
               pressure_limit_ff <= csr_data[skfl_pkg::ADC_W-1:0];
            skfl_pkg::CSR_CURRENT_LIMIT:
               current_limit_ff <= csr_data[skfl_pkg::ADC_W-1:0];
            default: ;
         endcase
      end
   end

   // per-word update
   always_comb begin
      prev_level_in   = prev_level_ff;
      pulse_count_in  = pulse_count_ff;
      window_base_in  = window_base_ff;
      window_start_in = window_start_ff;
      latched_in      = latched_ff;
      reason_in       = reason_ff;
      latched_time_in = latched_time_ff;

      count_step = pulse_count_ff;
      if (encoder_enable_ff && req_data.encoder_level && !prev_level_ff) begin
         count_step = pulse_count_ff + 32'd1;
      end
      elapsed       = req_data.now_ms - window_start_ff;
      window_done   = elapsed >= {16'd0, window_ms_ff};
      window_pulses = count_step - window_base_ff;
      over_trip     = encoder_enable_ff && window_done
                      && (window_pulses > {16'd0, pulse_max_ff});
      press_trip    = pressure_enable_ff
                      && (req_data.pressure_sample > pressure_limit_ff);
      curr_trip     = current_enable_ff
                      && (req_data.current_sample > current_limit_ff);

      if (req_data.cmd == skfl_pkg::CMD_CLEAR) begin
         latched_in      = 1'b0;
         reason_in       = skfl_pkg::REASON_NONE;
         latched_time_in = '0;
         pulse_count_in  = '0;
         window_base_in  = '0;
      end else begin
         if (encoder_enable_ff) begin
            prev_level_in  = req_data.encoder_level;
            pulse_count_in = count_step;
         end
         if (!latched_ff) begin
            // with encoder counting on, window restarts whenever it has run out, trip or not
            if (encoder_enable_ff && window_done) begin
               window_start_in = req_data.now_ms;
               window_base_in  = count_step;
            end
            if (over_trip) begin
               latched_in = 1'b1;
               reason_in  = skfl_pkg::REASON_OVERSPEED;
            end else if (press_trip) begin
               latched_in = 1'b1;
               reason_in  = skfl_pkg::REASON_PRESSURE;
            end else if (curr_trip) begin
               latched_in = 1'b1;
               reason_in  = skfl_pkg::REASON_CURRENT;
            end
            if (over_trip || press_trip || curr_trip) begin
               latched_time_in = req_data.now_ms;
            end
         end
      end

      result.kickout_active  = latched_in;
      result.kickout_reason  = reason_in;
      result.kickout_time_ms = latched_time_in;
      result.pulse_total     = pulse_count_in;
   end

   // output register with one-word skid
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (req_take) begin
         if (!out_valid_ff || rsp_take) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff   <= 1'b0;
         pulse_count_ff  <= '0;
         window_base_ff  <= '0;
         window_start_ff <= '0;
         latched_ff      <= 1'b0;
         reason_ff       <= skfl_pkg::REASON_NONE;
         latched_time_ff <= '0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (req_take) begin
            prev_level_ff   <= prev_level_in;
            pulse_count_ff  <= pulse_count_in;
            window_base_ff  <= window_base_in;
            window_start_ff <= window_start_in;
            latched_ff      <= latched_in;
            reason_ff       <= reason_in;
            latched_time_ff <= latched_time_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // skid word only exists behind a held output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word valid without output word");

   // latch flag and reason agree
   a_reason_matches: assert property (@(posedge clock) disable iff (reset)
      latched_ff == (reason_ff != skfl_pkg::REASON_NONE))
      else $error("latch flag and reason disagree");

   // a clear word empties latch and counts
   a_clear_effect: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.cmd == skfl_pkg::CMD_CLEAR) |=>
         (!latched_ff && pulse_count_ff == '0 && window_base_ff == '0
          && latched_time_ff == '0))
      else $error("clear did not reset latch state");

   // pulse count moves by at most one per poll word
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !(req_take && req_data.cmd == skfl_pkg::CMD_CLEAR) |=>
         (pulse_count_ff == $past(pulse_count_ff)
          || pulse_count_ff == $past(pulse_count_ff) + 32'd1))
      else $error("pulse count jumped");

   // a latched fault holds until a clear word
   a_latch_holds: assert property (@(posedge clock) disable iff (reset)
      (latched_ff && !(req_take && req_data.cmd == skfl_pkg::CMD_CLEAR)) |=>
         (latched_ff && $stable(reason_ff) && $stable(latched_time_ff)))
      else $error("latched fault changed without clear");

endmodule
